/* src/pss_pkg.sv */
package pss_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int OP_BITS        = 2;
    localparam int STEP_BITS      = 16;
    localparam int TIME_BITS      = 32;

    localparam logic [OP_BITS-1:0] OP_READ = 2'd0;
    localparam logic [OP_BITS-1:0] OP_TICK = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SET  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RAW_MIN       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAW_MAX       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAW_TOLERANCE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KPA_MIN       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KPA_MAX       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_MS       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIM_ENABLED   = 3'd6;

    localparam int RAW_MAX_RESET = 4095;
    localparam int KPA_MAX_RESET = 1000;
    localparam logic [STEP_BITS-1:0] STEP_MS_RESET = 16'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic tick;
        logic set;
        logic feed_on;
        logic suction_on;
    } sim_cmd_t;

endpackage

/* src/pss_divider.sv */
module pss_divider #(
    parameter int DIVISOR_BITS  = 12,
    parameter int QUOTIENT_BITS = 13
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [DIVISOR_BITS+QUOTIENT_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]               divisor,
    output logic                                  done,
    output logic [QUOTIENT_BITS-1:0]              quotient
);

    localparam int CNT_BITS = $clog2(QUOTIENT_BITS + 1);

    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [QUOTIENT_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [DIVISOR_BITS:0] shifted;
    logic [DIVISOR_BITS:0] trial;

    // one restoring step per cycle
    always_comb begin
        shifted    = {rem_reg, quo_reg[QUOTIENT_BITS-1]};
        trial      = shifted - {1'b0, dsr_reg};
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_next   = dividend[DIVISOR_BITS+QUOTIENT_BITS-1:QUOTIENT_BITS];
            quo_next   = dividend[QUOTIENT_BITS-1:0];
            dsr_next   = divisor;
            count_next = CNT_BITS'(QUOTIENT_BITS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIVISOR_BITS]) begin
                rem_next = trial[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[QUOTIENT_BITS-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[QUOTIENT_BITS-2:0], 1'b0};
            end
            count_next = count_reg - CNT_BITS'(1);
            if (count_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/pss_sim.sv */
module pss_sim #(
    parameter int PRESSURE_BITS = 13
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  pss_pkg::sim_cmd_t                      cmd,
    input  logic [pss_pkg::TIME_BITS-1:0]          now_ms,
    input  logic signed [PRESSURE_BITS-1:0]        new_pressure,
    input  logic signed [PRESSURE_BITS-1:0]        kpa_min,
    input  logic signed [PRESSURE_BITS-1:0]        kpa_max,
    input  logic [pss_pkg::STEP_BITS-1:0]          step_ms,
    input  logic                                   sim_enabled,
    output logic signed [PRESSURE_BITS-1:0]        sim_pressure
);

    logic signed [PRESSURE_BITS-1:0]     pressure_reg, pressure_next;
    logic [pss_pkg::TIME_BITS-1:0]       last_step_reg, last_step_next;

    logic [pss_pkg::TIME_BITS-1:0] elapsed;
    logic signed [PRESSURE_BITS:0] kmin_ext;
    logic signed [PRESSURE_BITS:0] kmax_ext;
    logic signed [PRESSURE_BITS:0] stepped;
    logic signed [PRESSURE_BITS:0] raised;
    logic signed [PRESSURE_BITS:0] lowered;
    logic                          inc;
    logic                          dec;

    always_comb begin
        elapsed  = now_ms - last_step_reg;
        kmin_ext = (PRESSURE_BITS+1)'(kpa_min);
        kmax_ext = (PRESSURE_BITS+1)'(kpa_max);
        inc      = cmd.feed_on && !cmd.suction_on;
        dec      = cmd.suction_on && !cmd.feed_on;
        stepped  = (PRESSURE_BITS+1)'(pressure_reg);
        if (inc) begin
            stepped = stepped + (PRESSURE_BITS+1)'(1);
        end else if (dec) begin
            stepped = stepped - (PRESSURE_BITS+1)'(1);
        end
        // raise to the lower bound first, then lower to the upper bound
        raised  = (stepped < kmin_ext) ? kmin_ext : stepped;
        lowered = (raised > kmax_ext) ? kmax_ext : raised;

        pressure_next  = pressure_reg;
        last_step_next = last_step_reg;
        if (cmd.set) begin
            pressure_next = new_pressure;
        end else if (cmd.tick && sim_enabled) begin
            if (last_step_reg == '0) begin
                last_step_next = now_ms;
            end else if (elapsed >= pss_pkg::TIME_BITS'(step_ms)) begin
                last_step_next = now_ms;
                pressure_next  = lowered[PRESSURE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressure_reg  <= '0;
            last_step_reg <= '0;
        end else begin
            pressure_reg  <= pressure_next;
            last_step_reg <= last_step_next;
        end
    end

    assign sim_pressure = pressure_reg;

endmodule

/* src/pressure_sample_scaler.sv */
// Pressure sample scaler. A read transaction checks a raw converter sample against the
// tolerated window around [raw_min, raw_max], clamps it and maps it linearly onto
// [kpa_min, kpa_max] (division truncates toward zero); out-of-window samples give 0 with
// valid_res low, and in simulation mode the stored simulated pressure is returned as
// valid. Tick and set transactions update the simulated pressure in the cycle they are
// accepted and return nothing; op code 3 is ignored. A converted read that needs the
// divider runs prep, start and divide, the radix-2 restoring divider retiring one
// quotient bit per cycle; reads in simulation mode, out of the window or with equal raw
// bounds skip from prep to done. The block takes one read at a time and accepts the next
// transaction once its result is parked in the output register. Configuration writes
// are always accepted and must be issued while idle.
module pressure_sample_scaler #(
    parameter int RAW_BITS      = 12,
    parameter int PRESSURE_BITS = 13
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,

    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [pss_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [pss_pkg::CFG_DATA_BITS-1:0]         cfg_data,

    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [pss_pkg::OP_BITS-1:0]               s_op,
    input  logic [RAW_BITS-1:0]                       s_raw_sample,
    input  logic                                      s_feed_on,
    input  logic                                      s_suction_on,
    input  logic [pss_pkg::TIME_BITS-1:0]             s_now_ms,
    input  logic signed [PRESSURE_BITS-1:0]           s_new_pressure,

    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [PRESSURE_BITS-1:0]           m_pressure_kpa,
    output logic                                      m_valid_res
);

    localparam int RB = RAW_BITS;
    localparam int PB = PRESSURE_BITS;
    localparam logic signed [PB+1:0] SAT_HI = {3'b000, {(PB-1){1'b1}}};
    localparam logic signed [PB+1:0] SAT_LO = {3'b111, {(PB-1){1'b0}}};

    // configuration registers
    logic [RB-1:0]                    raw_min_reg;
    logic [RB-1:0]                    raw_max_reg;
    logic [RB-1:0]                    raw_tol_reg;
    logic signed [PB-1:0]             kpa_min_reg;
    logic signed [PB-1:0]             kpa_max_reg;
    logic [pss_pkg::STEP_BITS-1:0]    step_ms_reg;
    logic                             sim_en_reg;

    pss_pkg::state_t state_reg, state_next;

    logic [RB-1:0]        raw_reg;
    logic [RB-1:0]        mag_a_reg;
    logic [PB-1:0]        mag_dk_reg;
    logic [RB-1:0]        mag_den_reg;
    logic                 neg_reg;
    logic signed [PB-1:0] res_kpa_reg;
    logic                 res_ok_reg;

    logic                 m_valid_reg, m_valid_next;
    logic signed [PB-1:0] m_kpa_reg;
    logic                 m_ok_reg;

    logic s_fire;
    logic div_start;
    logic div_done;
    logic out_load;
    logic prep_short;

    logic [PB-1:0]        quotient;
    logic [RB+PB-1:0]     product;
    logic signed [PB-1:0] sim_pressure;
    pss_pkg::sim_cmd_t    sim_cmd;

    // window check, clamp and operand magnitudes
    logic signed [RB+1:0] raw_w, lo_w, hi_w, tol_w, win_lo, win_hi;
    logic                 out_win;
    logic [RB-1:0]        clamp_raw;
    logic signed [RB:0]   num_a, den, neg_a, neg_den;
    logic signed [PB:0]   dk, neg_dk;
    logic [RB-1:0]        mag_a;
    logic [PB-1:0]        mag_dk;
    logic [RB-1:0]        mag_den;
    logic                 den_zero;

    // final correction
    logic signed [PB:0]   q_s;
    logic signed [PB+1:0] sum;
    logic signed [PB-1:0] fin_kpa;

    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        raw_w     = $signed({2'b00, raw_reg});
        lo_w      = $signed({2'b00, raw_min_reg});
        hi_w      = $signed({2'b00, raw_max_reg});
        tol_w     = $signed({2'b00, raw_tol_reg});
        win_lo    = lo_w - tol_w;
        win_hi    = hi_w + tol_w;
        out_win   = (raw_w < win_lo) || (raw_w > win_hi);
        clamp_raw = (raw_reg < raw_min_reg) ? raw_min_reg :
                    ((raw_reg > raw_max_reg) ? raw_max_reg : raw_reg);
        num_a     = $signed({1'b0, clamp_raw}) - $signed({1'b0, raw_min_reg});
        den       = $signed({1'b0, raw_max_reg}) - $signed({1'b0, raw_min_reg});
        dk        = (PB+1)'(kpa_max_reg) - (PB+1)'(kpa_min_reg);
        neg_a     = -num_a;
        neg_den   = -den;
        neg_dk    = -dk;
        mag_a     = num_a[RB] ? neg_a[RB-1:0] : num_a[RB-1:0];
        mag_den   = den[RB] ? neg_den[RB-1:0] : den[RB-1:0];
        mag_dk    = dk[PB] ? neg_dk[PB-1:0] : dk[PB-1:0];
        den_zero  = (den == '0);
        prep_short = sim_en_reg || out_win || den_zero;
    end

    assign product = (RB+PB)'(mag_a_reg) * (RB+PB)'(mag_dk_reg);

    always_comb begin
        q_s = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        sum = (PB+2)'(q_s) + (PB+2)'(kpa_min_reg);
        if (sum > SAT_HI) begin
            fin_kpa = SAT_HI[PB-1:0];
        end else if (sum < SAT_LO) begin
            fin_kpa = SAT_LO[PB-1:0];
        end else begin
            fin_kpa = sum[PB-1:0];
        end
    end

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pss_pkg::ST_IDLE: begin
                if (s_valid && s_op == pss_pkg::OP_READ) begin
                    state_next = pss_pkg::ST_PREP;
                end
            end
            pss_pkg::ST_PREP: begin
                state_next = prep_short ? pss_pkg::ST_DONE : pss_pkg::ST_START;
            end
            pss_pkg::ST_START: begin
                state_next = pss_pkg::ST_DIVIDE;
            end
            pss_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = pss_pkg::ST_DONE;
                end
            end
            pss_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            default: state_next = pss_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            pss_pkg::ST_IDLE:   s_ready   = 1'b1;
            pss_pkg::ST_START:  div_start = 1'b1;
            pss_pkg::ST_DONE:   out_load  = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pss_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            raw_min_reg <= '0;
            raw_max_reg <= RB'(pss_pkg::RAW_MAX_RESET);
            raw_tol_reg <= '0;
            kpa_min_reg <= '0;
            kpa_max_reg <= PB'(pss_pkg::KPA_MAX_RESET);
            step_ms_reg <= pss_pkg::STEP_MS_RESET;
            sim_en_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pss_pkg::REG_RAW_MIN:       raw_min_reg <= cfg_data[RB-1:0];
                    pss_pkg::REG_RAW_MAX:       raw_max_reg <= cfg_data[RB-1:0];
                    pss_pkg::REG_RAW_TOLERANCE: raw_tol_reg <= cfg_data[RB-1:0];
                    pss_pkg::REG_KPA_MIN:       kpa_min_reg <= cfg_data[PB-1:0];
                    pss_pkg::REG_KPA_MAX:       kpa_max_reg <= cfg_data[PB-1:0];
                    pss_pkg::REG_STEP_MS:
                        step_ms_reg <= cfg_data[pss_pkg::STEP_BITS-1:0];
                    pss_pkg::REG_SIM_ENABLED:   sim_en_reg  <= cfg_data[0];
                    default: begin
                        sim_en_reg <= sim_en_reg;
                    end
                endcase
            end
        end

        if (s_fire) begin
            raw_reg <= s_raw_sample;
        end
        if (state_reg == pss_pkg::ST_PREP) begin
            mag_a_reg   <= mag_a;
            mag_dk_reg  <= mag_dk;
            mag_den_reg <= mag_den;
            neg_reg     <= num_a[RB] ^ dk[PB] ^ den[RB];
            if (sim_en_reg) begin
                res_kpa_reg <= sim_pressure;
                res_ok_reg  <= 1'b1;
            end else if (out_win) begin
                res_kpa_reg <= '0;
                res_ok_reg  <= 1'b0;
            end else begin
                res_kpa_reg <= kpa_min_reg;
                res_ok_reg  <= 1'b1;
            end
        end
        if (state_reg == pss_pkg::ST_DIVIDE && div_done) begin
            res_kpa_reg <= fin_kpa;
            res_ok_reg  <= 1'b1;
        end
        if (out_load) begin
            m_kpa_reg <= res_kpa_reg;
            m_ok_reg  <= res_ok_reg;
        end
    end

    assign sim_cmd.tick       = s_fire && (s_op == pss_pkg::OP_TICK);
    assign sim_cmd.set        = s_fire && (s_op == pss_pkg::OP_SET);
    assign sim_cmd.feed_on    = s_feed_on;
    assign sim_cmd.suction_on = s_suction_on;

    pss_sim #(
        .PRESSURE_BITS (PB)
    ) u_sim (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (sim_cmd),
        .now_ms       (s_now_ms),
        .new_pressure (s_new_pressure),
        .kpa_min      (kpa_min_reg),
        .kpa_max      (kpa_max_reg),
        .step_ms      (step_ms_reg),
        .sim_enabled  (sim_en_reg),
        .sim_pressure (sim_pressure)
    );

    pss_divider #(
        .DIVISOR_BITS  (RB),
        .QUOTIENT_BITS (PB)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (mag_den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_valid        = m_valid_reg;
    assign m_pressure_kpa = m_kpa_reg;
    assign m_valid_res    = m_ok_reg;

`ifndef SYNTHESIS
    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_pressure_kpa == '0)
        else $error("invalid result with nonzero pressure");

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == pss_pkg::ST_DIVIDE)
        else $error("divider finished outside the divide state");

    a_update_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_op != pss_pkg::OP_READ |=> state_reg == pss_pkg::ST_IDLE)
        else $error("tick or set transaction left the idle state");

    a_read_enters_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_op == pss_pkg::OP_READ |=> state_reg == pss_pkg::ST_PREP)
        else $error("read transaction did not start the sequencer");
`endif

endmodule

/* test/pressure_sample_scaler_test.sv */
`timescale 1ns / 1ps

module pressure_sample_scaler_test;

    localparam int RAW_BITS      = 12;
    localparam int PRESSURE_BITS = 13;
    localparam int RAW_TOP       = 2**RAW_BITS - 1;
    localparam int KPA_TOP       = 2**(PRESSURE_BITS-1) - 1;
    localparam int KPA_BOTTOM    = -KPA_TOP - 1;
    localparam int DRAIN_CYCLES  = 2 * (PRESSURE_BITS + 5);
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 75;
    localparam int IDLE_PCT      = 32;

    localparam logic [pss_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [pss_pkg::OP_BITS-1:0]     op;
        logic [RAW_BITS-1:0]             raw;
        logic                            feed;
        logic                            suction;
        logic [pss_pkg::TIME_BITS-1:0]   now;
        logic signed [PRESSURE_BITS-1:0] newp;
    } sample_item_t;

    typedef struct packed {
        logic signed [PRESSURE_BITS-1:0] kpa;
        logic                            ok;
    } reading_t;

    typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic [pss_pkg::CFG_INDEX_BITS-1:0] idx;
        logic [pss_pkg::CFG_DATA_BITS-1:0]  data;
        sample_item_t                       it;
        bit                                 fixed;
        reading_t                           want;
    } dir_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [pss_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
    logic [pss_pkg::CFG_DATA_BITS-1:0]   cfg_data;
    logic                                s_valid;
    logic                                s_ready;
    logic [pss_pkg::OP_BITS-1:0]         s_op;
    logic [RAW_BITS-1:0]                 s_raw_sample;
    logic                                s_feed_on;
    logic                                s_suction_on;
    logic [pss_pkg::TIME_BITS-1:0]       s_now_ms;
    logic signed [PRESSURE_BITS-1:0]     s_new_pressure;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [PRESSURE_BITS-1:0]     m_pressure_kpa;
    logic                                m_valid_res;

    // calibration and simulated sensor state as the block should hold it
    int unsigned    cal_raw_lo;
    int unsigned    cal_raw_hi;
    int unsigned    cal_tol;
    int             cal_kpa_lo;
    int             cal_kpa_hi;
    int unsigned    cal_step;
    bit             cal_sim;
    longint         sim_kpa;
    logic [31:0]    last_step_ms;
    logic [31:0]    sim_clock;

    reading_t       pending_readings[$];
    reading_t       got_want;
    reading_t       no_reading;
    dir_row_t       directed[$];

    int             mismatches;
    int             readings_checked;
    int             items_counted;
    int             cfg_writes;
    int             quiet_cycles;
    int             tx_idle_pct;
    int             rx_idle_pct;
    int             hold_requests;
    int             holds_done;

    pressure_sample_scaler #(
        .RAW_BITS      (RAW_BITS),
        .PRESSURE_BITS (PRESSURE_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_raw_sample   (s_raw_sample),
        .s_feed_on      (s_feed_on),
        .s_suction_on   (s_suction_on),
        .s_now_ms       (s_now_ms),
        .s_new_pressure (s_new_pressure),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pressure_kpa (m_pressure_kpa),
        .m_valid_res    (m_valid_res)
    );

    always #5 aclk = ~aclk;

    function automatic reading_t predict_reading(logic [RAW_BITS-1:0] raw);
        longint   lo;
        longint   hi;
        longint   tol;
        longint   s;
        longint   c;
        longint   den;
        longint   p;
        reading_t r;
        lo   = cal_raw_lo;
        hi   = cal_raw_hi;
        tol  = cal_tol;
        s    = raw;
        r.ok = 1'b1;
        if (cal_sim) begin
            p = sim_kpa;
        end else if (s < lo - tol || s > hi + tol) begin
            p    = 0;
            r.ok = 1'b0;
        end else begin
            c   = (s < lo) ? lo : ((s > hi) ? hi : s);
            den = hi - lo;
            if (den == 0) begin
                p = cal_kpa_lo;
            end else begin
                p = (c - lo) * (longint'(cal_kpa_hi) - longint'(cal_kpa_lo)) / den
                    + cal_kpa_lo;
            end
        end
        if (p > KPA_TOP) begin
            p = KPA_TOP;
        end
        if (p < KPA_BOTTOM) begin
            p = KPA_BOTTOM;
        end
        r.kpa = PRESSURE_BITS'(p);
        return r;
    endfunction

    // returns 1 unless the transaction is op code 3 or a tick outside simulation mode
    function automatic bit apply_item(sample_item_t it, bit fixed, reading_t want);
        bit counts;
        counts = 1'b1;
        case (it.op)
            pss_pkg::OP_READ: begin
                pending_readings.push_back(fixed ? want : predict_reading(it.raw));
            end
            pss_pkg::OP_TICK: begin
                if (!cal_sim) begin
                    counts = 1'b0;
                end else if (last_step_ms == 32'd0) begin
                    last_step_ms = it.now;
                end else if (it.now - last_step_ms >= cal_step) begin
                    last_step_ms = it.now;
                    if (it.feed && !it.suction) begin
                        sim_kpa++;
                    end else if (it.suction && !it.feed) begin
                        sim_kpa--;
                    end
                    if (sim_kpa < cal_kpa_lo) begin
                        sim_kpa = cal_kpa_lo;
                    end
                    if (sim_kpa > cal_kpa_hi) begin
                        sim_kpa = cal_kpa_hi;
                    end
                end
            end
            pss_pkg::OP_SET: begin
                sim_kpa = it.newp;
            end
            default: begin
                counts = 1'b0;
            end
        endcase
        return counts;
    endfunction

    function automatic void add_cfg(logic [pss_pkg::CFG_INDEX_BITS-1:0] idx,
                                    logic [31:0] data);
        dir_row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.it    = '0;
        r.fixed = 1'b0;
        r.want  = '0;
        directed.push_back(r);
    endfunction

    function automatic void add_item(logic [pss_pkg::OP_BITS-1:0] op,
                                     logic [RAW_BITS-1:0] raw,
                                     logic feed, logic suction, logic [31:0] now,
                                     logic signed [PRESSURE_BITS-1:0] newp);
        dir_row_t r;
        r.kind       = ROW_ITEM;
        r.idx        = '0;
        r.data       = '0;
        r.it.op      = op;
        r.it.raw     = raw;
        r.it.feed    = feed;
        r.it.suction = suction;
        r.it.now     = now;
        r.it.newp    = newp;
        r.fixed      = 1'b0;
        r.want       = '0;
        directed.push_back(r);
    endfunction

    // read with the expected reading written out by hand
    function automatic void add_read(logic [RAW_BITS-1:0] raw,
                                     logic signed [PRESSURE_BITS-1:0] kpa, logic ok);
        dir_row_t r;
        r.kind    = ROW_ITEM;
        r.idx     = '0;
        r.data    = '0;
        r.it      = '0;
        r.it.op   = pss_pkg::OP_READ;
        r.it.raw  = raw;
        r.fixed   = 1'b1;
        r.want.kpa = kpa;
        r.want.ok  = ok;
        directed.push_back(r);
    endfunction

    function automatic sample_item_t random_item();
        sample_item_t it;
        int           pick;
        int           base;
        it.op      = pss_pkg::OP_READ;
        it.raw     = RAW_BITS'($urandom);
        it.feed    = 1'($urandom);
        it.suction = 1'($urandom);
        it.now     = $urandom;
        it.newp    = PRESSURE_BITS'($urandom);
        pick       = int'($urandom_range(99));
        if (cal_sim) begin
            if (pick < 15) begin
                it.op = pss_pkg::OP_SET;
                if (pick < 6) begin
                    base = ((pick % 2) == 0 ? cal_kpa_lo : cal_kpa_hi)
                           + int'($urandom_range(4)) - 2;
                    it.newp = PRESSURE_BITS'(base);
                end
            end else if (pick < 70) begin
                it.op = pss_pkg::OP_TICK;
                if (pick < 67) begin
                    sim_clock = sim_clock + $urandom_range(2 * cal_step + 2);
                    it.now    = sim_clock;
                end else begin
                    sim_clock = it.now;
                end
            end else if (pick >= 95) begin
                it.op = OP_UNUSED;
            end
        end else begin
            if (pick < 45) begin
                case ($urandom_range(3))
                    0: base = int'(cal_raw_lo) - int'(cal_tol);
                    1: base = int'(cal_raw_hi) + int'(cal_tol);
                    2: base = int'(cal_raw_lo);
                    default: base = int'(cal_raw_hi);
                endcase
                base = base + int'($urandom_range(4)) - 2;
                if (base < 0) begin
                    base = 0;
                end
                if (base > RAW_TOP) begin
                    base = RAW_TOP;
                end
                it.raw = RAW_BITS'(base);
            end else if (pick >= 95) begin
                it.op = OP_UNUSED;
            end else if (pick >= 85) begin
                it.op = pss_pkg::OP_TICK;
            end else if (pick >= 75) begin
                it.op = pss_pkg::OP_SET;
            end
        end
        return it;
    endfunction

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [pss_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            pss_pkg::REG_RAW_MIN:       cal_raw_lo = data[RAW_BITS-1:0];
            pss_pkg::REG_RAW_MAX:       cal_raw_hi = data[RAW_BITS-1:0];
            pss_pkg::REG_RAW_TOLERANCE: cal_tol    = data[RAW_BITS-1:0];
            pss_pkg::REG_KPA_MIN:       cal_kpa_lo = $signed(data[PRESSURE_BITS-1:0]);
            pss_pkg::REG_KPA_MAX:       cal_kpa_hi = $signed(data[PRESSURE_BITS-1:0]);
            pss_pkg::REG_STEP_MS:       cal_step   = data[pss_pkg::STEP_BITS-1:0];
            pss_pkg::REG_SIM_ENABLED:   cal_sim    = data[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_item(sample_item_t it, bit fixed, reading_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= it.op;
        s_raw_sample   <= it.raw;
        s_feed_on      <= it.feed;
        s_suction_on   <= it.suction;
        s_now_ms       <= it.now;
        s_new_pressure <= it.newp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (apply_item(it, fixed, want)) begin
            items_counted++;
        end
    endtask

    task automatic configure_phase(int phase);
        int raw_lo;
        int raw_hi;
        int tol;
        int k_lo;
        int k_hi;
        int stp;
        case (phase)
            0: begin
                raw_lo = 0;
                raw_hi = RAW_TOP;
                tol    = 0;
                k_lo   = KPA_BOTTOM;
                k_hi   = KPA_TOP;
                stp    = 65535;
            end
            1: begin
                raw_lo = RAW_TOP;
                raw_hi = 0;
                tol    = RAW_TOP;
                k_lo   = KPA_TOP;
                k_hi   = KPA_BOTTOM;
                stp    = 0;
            end
            default: begin
                raw_lo = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(RAW_TOP));
                raw_hi = ($urandom_range(3) == 0) ? RAW_TOP : int'($urandom_range(RAW_TOP));
                if ($urandom_range(9) == 0) begin
                    raw_hi = raw_lo;
                end
                case ($urandom_range(3))
                    0: tol = 0;
                    1: tol = RAW_TOP;
                    2: tol = int'($urandom_range(200));
                    default: tol = int'($urandom_range(RAW_TOP));
                endcase
                k_lo = KPA_BOTTOM + int'($urandom_range(2 * KPA_TOP + 1));
                k_hi = KPA_BOTTOM + int'($urandom_range(2 * KPA_TOP + 1));
                if ((phase % 2) == 0 && $urandom_range(1) == 0) begin
                    // narrow pressure band so ticks run into both clamps
                    k_hi = k_lo + int'($urandom_range(40));
                    if (k_hi > KPA_TOP) begin
                        k_hi = KPA_TOP;
                    end
                end
                case ($urandom_range(3))
                    0: stp = 0;
                    1: stp = 1;
                    2: stp = int'($urandom_range(300));
                    default: stp = 65535;
                endcase
            end
        endcase
        write_reg(pss_pkg::REG_RAW_MIN, raw_lo);
        write_reg(pss_pkg::REG_RAW_MAX, raw_hi);
        write_reg(pss_pkg::REG_RAW_TOLERANCE, tol);
        write_reg(pss_pkg::REG_KPA_MIN, k_lo);
        write_reg(pss_pkg::REG_KPA_MAX, k_hi);
        write_reg(pss_pkg::REG_STEP_MS, stp);
        write_reg(pss_pkg::REG_SIM_ENABLED, ((phase % 2) == 0) ? 32'd1 : 32'd0);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            readings_checked++;
            if (pending_readings.size() == 0) begin
                mismatches++;
                $error("unexpected transaction: pressure_kpa %0d valid_res %0b",
                       m_pressure_kpa, m_valid_res);
            end else begin
                got_want = pending_readings.pop_front();
                if (m_pressure_kpa !== got_want.kpa) begin
                    mismatches++;
                    $error("pressure_kpa: expected %0d, actual %0d",
                           got_want.kpa, m_pressure_kpa);
                end
                if (m_valid_res !== got_want.ok) begin
                    mismatches++;
                    $error("valid_res: expected %0b, actual %0b",
                           got_want.ok, m_valid_res);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("pressure_sample_scaler test failed");
            $finish;
        end
    end

    // result side ready, with one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done < hold_requests) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int target;
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_op           <= pss_pkg::OP_READ;
        s_raw_sample   <= '0;
        s_feed_on      <= 1'b0;
        s_suction_on   <= 1'b0;
        s_now_ms       <= '0;
        s_new_pressure <= '0;
        cal_raw_lo     = 0;
        cal_raw_hi     = pss_pkg::RAW_MAX_RESET;
        cal_tol        = 0;
        cal_kpa_lo     = 0;
        cal_kpa_hi     = pss_pkg::KPA_MAX_RESET;
        cal_step       = pss_pkg::STEP_MS_RESET;
        cal_sim        = 1'b0;
        sim_kpa        = 0;
        last_step_ms   = '0;
        sim_clock      = 32'd1000;
        no_reading     = '0;
        tx_idle_pct    = IDLE_PCT;
        rx_idle_pct    = IDLE_PCT;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration
        add_read(12'd0, 13'sd0, 1'b1);
        add_read(12'd4095, 13'sd1000, 1'b1);
        add_item(OP_UNUSED, 12'd4095, 1'b1, 1'b1, 32'hffff_ffff, 13'sd4095);
        add_item(pss_pkg::OP_TICK, 12'd0, 1'b1, 1'b0, 32'd500, 13'sd0);
        // tolerance window edges over the full pressure span
        add_cfg(pss_pkg::REG_RAW_MIN, 32'd100);
        add_cfg(pss_pkg::REG_RAW_MAX, 32'd3000);
        add_cfg(pss_pkg::REG_RAW_TOLERANCE, 32'd50);
        add_cfg(pss_pkg::REG_KPA_MIN, 32'hffff_f000);
        add_cfg(pss_pkg::REG_KPA_MAX, 32'd4095);
        add_read(12'd49, 13'sd0, 1'b0);
        add_read(12'd50, -13'sd4096, 1'b1);
        add_read(12'd3050, 13'sd4095, 1'b1);
        add_read(12'd3051, 13'sd0, 1'b0);
        add_item(pss_pkg::OP_READ, 12'd1234, 1'b0, 1'b0, 32'd0, 13'sd0);
        // equal raw bounds
        add_cfg(pss_pkg::REG_RAW_MIN, 32'd2000);
        add_cfg(pss_pkg::REG_RAW_MAX, 32'd2000);
        add_cfg(pss_pkg::REG_RAW_TOLERANCE, 32'd4095);
        add_read(12'd0, -13'sd4096, 1'b1);
        add_read(12'd4095, -13'sd4096, 1'b1);
        // crossed raw bounds
        add_cfg(pss_pkg::REG_RAW_MIN, 32'd3000);
        add_cfg(pss_pkg::REG_RAW_MAX, 32'd1000);
        add_cfg(pss_pkg::REG_RAW_TOLERANCE, 32'd2500);
        add_item(pss_pkg::OP_READ, 12'd2000, 1'b0, 1'b0, 32'd0, 13'sd0);
        add_item(pss_pkg::OP_READ, 12'd3200, 1'b0, 1'b0, 32'd0, 13'sd0);
        // simulated sensor
        add_cfg(pss_pkg::REG_KPA_MIN, 32'hffff_fff6);
        add_cfg(pss_pkg::REG_KPA_MAX, 32'd10);
        add_cfg(pss_pkg::REG_STEP_MS, 32'd100);
        add_cfg(pss_pkg::REG_SIM_ENABLED, 32'd1);
        add_read(12'd4095, 13'sd0, 1'b1);
        add_item(pss_pkg::OP_SET, 12'd0, 1'b0, 1'b0, 32'd0, 13'sd4095);
        add_read(12'd0, 13'sd4095, 1'b1);
        add_item(pss_pkg::OP_SET, 12'd0, 1'b0, 1'b0, 32'd0, -13'sd4096);
        add_read(12'd0, -13'sd4096, 1'b1);
        add_item(pss_pkg::OP_TICK, 12'd0, 1'b1, 1'b0, 32'd0, 13'sd0);
        add_item(pss_pkg::OP_TICK, 12'd0, 1'b1, 1'b0, 32'd1000, 13'sd0);
        add_item(pss_pkg::OP_TICK, 12'd0, 1'b1, 1'b0, 32'd1100, 13'sd0);
        add_item(pss_pkg::OP_READ, 12'd0, 1'b0, 1'b0, 32'd0, 13'sd0);
        add_item(pss_pkg::OP_TICK, 12'd0, 1'b1, 1'b1, 32'hffff_ffff, 13'sd0);
        add_item(pss_pkg::OP_TICK, 12'd0, 1'b1, 1'b0, 32'h0000_0050, 13'sd0);
        add_item(pss_pkg::OP_TICK, 12'd0, 1'b1, 1'b0, 32'h0000_0063, 13'sd0);
        add_item(pss_pkg::OP_READ, 12'd0, 1'b0, 1'b0, 32'd0, 13'sd0);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                write_reg(directed[i].idx, directed[i].data);
            end else begin
                send_item(directed[i].it, directed[i].fixed, directed[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            configure_phase(phase);
            tx_idle_pct = (phase == 5) ? 0 : IDLE_PCT;
            rx_idle_pct = (phase == 5) ? 0 : IDLE_PCT;
            target      = items_counted + PHASE_ITEMS;
            while (items_counted < target) begin
                if (phase == 3 && hold_requests == 0 && items_counted >= target - 60) begin
                    hold_requests++;
                end
                send_item(random_item(), 1'b0, no_reading);
            end
        end
        settle();

        $display("covered %0d directed rows and %0d calibration phases",
                 directed.size(), PHASES);
        $display("%0d effective transactions, %0d readings checked, %0d register writes",
                 items_counted, readings_checked, cfg_writes);
        if (mismatches == 0) begin
            $display("pressure_sample_scaler test passed");
        end else begin
            $display("pressure_sample_scaler test failed");
        end
        $finish;
    end

endmodule
